>>> rtl/smpq_pkg.sv
// Shared types and codes for the sorted priority queue.
// Holds the request and response transaction structs and the opcode/status codes.
// No dependencies.
`timescale 1ns / 1ps

package smpq_pkg;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   localparam int VALUE_BITS     = 32;
   localparam int PRIO_IN_BITS   = 8;
   localparam int OCC_BITS       = 5;

   localparam logic signed [VALUE_BITS-1:0] EMPTY_VALUE = -32'sd1;

   typedef struct packed {
      opcode_type                     opcode;
      logic signed [VALUE_BITS-1:0]   entry_value;
      logic [PRIO_IN_BITS-1:0]        entry_priority;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0]   result_value;
      status_type                     status;
      logic [OCC_BITS-1:0]            occupancy;
   } rsp_type;

endpackage

>>> rtl/smpq_cell.sv
// One slot of the sorted queue: a data word and a priority.
// Compares its priority with the incoming one and shifts with its neighbors.
// Depends on smpq_pkg for the data width.
`timescale 1ns / 1ps

module smpq_cell #(
   parameter int INDEX         = 0,
   parameter int COUNT_BITS    = 5,
   parameter int PRIORITY_BITS = 8
) (
   input  logic                                    clock,
   input  logic                                    enq_en,
   input  logic                                    deq_en,
   input  logic [COUNT_BITS-1:0]                   count,
   input  logic signed [smpq_pkg::VALUE_BITS-1:0]  new_value,
   input  logic [PRIORITY_BITS-1:0]                new_priority,
   input  logic                                    prev_gt,
   input  logic signed [smpq_pkg::VALUE_BITS-1:0]  prev_value,
   input  logic [PRIORITY_BITS-1:0]                prev_priority,
   input  logic signed [smpq_pkg::VALUE_BITS-1:0]  next_value,
   input  logic [PRIORITY_BITS-1:0]                next_priority,
   output logic                                    gt,
   output logic signed [smpq_pkg::VALUE_BITS-1:0]  value,
   output logic [PRIORITY_BITS-1:0]                priority_out
);

   logic signed [smpq_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic [PRIORITY_BITS-1:0]               prio_ff, prio_in;
   logic                                   occupied;

   // slot holds a live entry when its index is below the fill count
   assign occupied = (count > COUNT_BITS'(INDEX));
   assign gt       = occupied && (prio_ff > new_priority);

   always_comb begin
      value_in = value_ff;
      prio_in  = prio_ff;
      if (enq_en) begin
         if (prev_gt) begin
            // make room: take the entry from the lower slot
            value_in = prev_value;
            prio_in  = prev_priority;
         end else if (gt || !occupied) begin
            value_in = new_value;
            prio_in  = new_priority;
         end
      end else if (deq_en) begin
         // advance toward the front
         value_in = next_value;
         prio_in  = next_priority;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign value        = value_ff;
   assign priority_out = prio_ff;

endmodule

>>> rtl/stable_min_priority_queue.sv
// Top level of the sorted priority queue: a row of smpq_cell slots,
// the fill counter and the response register. Depends on smpq_pkg and smpq_cell.
//
// Usage:
//   Drive req_data and raise start; the transaction is taken at the rising
//   edge where start is high and busy is low. busy stays low, so one
//   transaction is taken every cycle.
//   Enqueue places the entry behind every stored entry of lower or equal
//   priority; dequeue returns the front entry (smallest priority value).
//   Each transaction yields one response on rsp_data, marked by rsp_strobe
//   for exactly one cycle, in the cycle after acceptance (throughput 1
//   per cycle). All slots compare against the new priority in parallel and
//   shift with their neighbors in the cycle of acceptance.
//   The receiver cannot stall; a response not taken in its cycle is lost.
//   Dequeue on an empty queue returns -1 with the empty status; enqueue on a
//   full queue is dropped with the full status.
//   Synchronous reset empties the queue and clears the response strobe.
`timescale 1ns / 1ps

module stable_min_priority_queue #(
   parameter int CAPACITY      = 16,
   parameter int PRIORITY_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  smpq_pkg::req_type req_data,
   output logic              rsp_strobe,
   output smpq_pkg::rsp_type rsp_data
);

   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   strobe_ff, strobe_in;
   smpq_pkg::rsp_type      rsp_ff, rsp_in;

   logic                   accept;
   logic                   is_full;
   logic                   is_empty;
   logic                   enq_en;
   logic                   deq_en;
   logic [PRIORITY_BITS-1:0] new_priority;

   logic                                   gt_w    [CAPACITY];
   logic signed [smpq_pkg::VALUE_BITS-1:0] value_w [CAPACITY];
   logic [PRIORITY_BITS-1:0]               prio_w  [CAPACITY];

   assign busy         = 1'b0;
   assign accept       = start && !busy;
   assign is_full      = (count_ff == COUNT_BITS'(CAPACITY));
   assign is_empty     = (count_ff == '0);
   assign new_priority = PRIORITY_BITS'(req_data.entry_priority);
   assign enq_en = accept && (req_data.opcode == smpq_pkg::OP_ENQUEUE) && !is_full;
   assign deq_en = accept && (req_data.opcode == smpq_pkg::OP_DEQUEUE) && !is_empty;

   genvar i;
   generate
      for (i = 0; i < CAPACITY; i++) begin : g_cell
         logic                                   prev_gt;
         logic signed [smpq_pkg::VALUE_BITS-1:0] prev_value, next_value;
         logic [PRIORITY_BITS-1:0]               prev_prio, next_prio;

         if (i == 0) begin : g_first
            assign prev_gt    = 1'b0;
            assign prev_value = req_data.entry_value;
            assign prev_prio  = new_priority;
         end else begin : g_mid
            assign prev_gt    = gt_w[i-1];
            assign prev_value = value_w[i-1];
            assign prev_prio  = prio_w[i-1];
         end

         if (i == CAPACITY - 1) begin : g_last
            assign next_value = value_w[i];
            assign next_prio  = prio_w[i];
         end else begin : g_inner
            assign next_value = value_w[i+1];
            assign next_prio  = prio_w[i+1];
         end

         smpq_cell #(
            .INDEX         (i),
            .COUNT_BITS    (COUNT_BITS),
            .PRIORITY_BITS (PRIORITY_BITS)
         ) u_cell (
            .clock         (clock),
            .enq_en        (enq_en),
            .deq_en        (deq_en),
            .count         (count_ff),
            .new_value     (req_data.entry_value),
            .new_priority  (new_priority),
            .prev_gt       (prev_gt),
            .prev_value    (prev_value),
            .prev_priority (prev_prio),
            .next_value    (next_value),
            .next_priority (next_prio),
            .gt            (gt_w[i]),
            .value         (value_w[i]),
            .priority_out  (prio_w[i])
         );
      end
   endgenerate

   always_comb begin
      count_in  = count_ff;
      strobe_in = accept;
      rsp_in    = rsp_ff;
      if (accept) begin
         if (req_data.opcode == smpq_pkg::OP_ENQUEUE) begin
            rsp_in.result_value = '0;
            if (is_full) begin
               rsp_in.status = smpq_pkg::ST_FULL;
            end else begin
               count_in      = count_ff + COUNT_BITS'(1);
               rsp_in.status = smpq_pkg::ST_ENQUEUED;
            end
         end else begin
            if (is_empty) begin
               rsp_in.result_value = smpq_pkg::EMPTY_VALUE;
               rsp_in.status       = smpq_pkg::ST_EMPTY;
            end else begin
               count_in            = count_ff - COUNT_BITS'(1);
               rsp_in.result_value = value_w[0];
               rsp_in.status       = smpq_pkg::ST_DEQUEUED;
            end
         end
         rsp_in.occupancy = smpq_pkg::OCC_BITS'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
